// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared function codes, the control record that travels with each item and
// the default word format.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int unsigned CAU_WORD_BITS = 32;
    localparam int unsigned CAU_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        FUNC_ADD  = 3'd0,
        FUNC_SUB  = 3'd1,
        FUNC_MUL  = 3'd2,
        FUNC_DIV  = 3'd3,
        FUNC_MAG  = 3'd4,
        FUNC_QUOT = 3'd5,
        FUNC_REM  = 3'd6
    } func_t;

    typedef struct packed {
        func_t func;
        logic  dz;
        logic  ovf;
        logic  neg_re;
        logic  neg_im;
        logic  big_re;
        logic  big_im;
    } ctrl_t;

endpackage

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Four stages: operand products, sums, rounding or absolute value, and the
// divider setup with its early overflow check.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int unsigned WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int unsigned FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        in_func,
    input  logic signed [WORD_BITS-1:0]       in_a_re,
    input  logic signed [WORD_BITS-1:0]       in_a_im,
    input  logic signed [WORD_BITS-1:0]       in_b_re,
    input  logic signed [WORD_BITS-1:0]       in_b_im,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cau_pkg::ctrl_t                    out_ctrl,
    output logic [2*WORD_BITS-1:0]            out_den,
    output logic [2*WORD_BITS-1:0]            out_r_re,
    output logic [2*WORD_BITS-1:0]            out_r_im,
    output logic [WORD_BITS:0]                out_nlo_re,
    output logic [WORD_BITS:0]                out_nlo_im,
    output logic [6*WORD_BITS-1:0]            out_side
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned QB = W + 1;
    localparam int unsigned DW = 2 * W;
    localparam int unsigned SF = 2 * W + 2;
    localparam int unsigned NM = 2 * W + F;
    localparam int unsigned HW = NM - QB;
    localparam int unsigned CW = (HW > DW) ? HW : DW;
    localparam logic signed [SF-1:0] HALF = SF'(F > 0 ? 1 : 0) << (F > 0 ? F - 1 : 0);

    function automatic logic [W:0] sat_word(input logic signed [SF-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[SF-1:W-1];
        all_zeros = ~|v[SF-1:W-1];
        if (all_ones || all_zeros) begin
            sat_word = {1'b0, v[W-1:0]};
        end else begin
            sat_word = {1'b1, v[SF-1], {(W-1){~v[SF-1]}}};
        end
    endfunction

    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg;
    logic en_a, en_b, en_c, en_d;

    assign en_d     = !v_d_reg || out_ready;
    assign en_c     = !v_c_reg || en_d;
    assign en_b     = !v_b_reg || en_c;
    assign en_a     = !v_a_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end else begin
            if (en_a) v_a_reg <= in_valid;
            if (en_b) v_b_reg <= v_a_reg;
            if (en_c) v_c_reg <= v_b_reg;
            if (en_d) v_d_reg <= v_c_reg;
        end
    end

    // Stage A: products and the plain sums.
    cau_pkg::func_t             func_in;
    logic signed [W-1:0]        x0, x1;
    logic signed [W:0]          add_re_next, add_im_next;

    cau_pkg::func_t             func_a_reg;
    logic [4*W-1:0]             ab_a_reg;
    logic signed [DW-1:0]       p_rr_a_reg, p_ii_a_reg, p_ri_a_reg, p_ir_a_reg;
    logic signed [DW-1:0]       sq0_a_reg, sq1_a_reg;
    logic signed [W:0]          add_re_a_reg, add_im_a_reg;

    always_comb begin
        func_in = cau_pkg::func_t'(in_func);
        x0 = (func_in == cau_pkg::FUNC_MAG) ? in_a_re : in_b_re;
        x1 = (func_in == cau_pkg::FUNC_MAG) ? in_a_im : in_b_im;
        if (func_in == cau_pkg::FUNC_SUB) begin
            add_re_next = $signed({in_a_re[W-1], in_a_re}) - $signed({in_b_re[W-1], in_b_re});
            add_im_next = $signed({in_a_im[W-1], in_a_im}) - $signed({in_b_im[W-1], in_b_im});
        end else begin
            add_re_next = $signed({in_a_re[W-1], in_a_re}) + $signed({in_b_re[W-1], in_b_re});
            add_im_next = $signed({in_a_im[W-1], in_a_im}) + $signed({in_b_im[W-1], in_b_im});
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a && in_valid) begin
            func_a_reg   <= func_in;
            ab_a_reg     <= {in_a_re, in_a_im, in_b_re, in_b_im};
            p_rr_a_reg   <= in_a_re * in_b_re;
            p_ii_a_reg   <= in_a_im * in_b_im;
            p_ri_a_reg   <= in_a_re * in_b_im;
            p_ir_a_reg   <= in_a_im * in_b_re;
            sq0_a_reg    <= x0 * x0;
            sq1_a_reg    <= x1 * x1;
            add_re_a_reg <= add_re_next;
            add_im_a_reg <= add_im_next;
        end
    end

    // Stage B: cross sums and the squared magnitude.
    logic signed [DW:0]   t_re_next, t_im_next;
    logic [DW-1:0]        den_next;

    cau_pkg::func_t       func_b_reg;
    logic [4*W-1:0]       ab_b_reg;
    logic signed [DW:0]   t_re_b_reg, t_im_b_reg;
    logic [DW-1:0]        den_b_reg;
    logic signed [W:0]    add_re_b_reg, add_im_b_reg;

    always_comb begin
        if (func_a_reg == cau_pkg::FUNC_MUL) begin
            t_re_next = p_rr_a_reg - p_ii_a_reg;
            t_im_next = p_ri_a_reg + p_ir_a_reg;
        end else begin
            t_re_next = p_rr_a_reg + p_ii_a_reg;
            t_im_next = p_ir_a_reg - p_ri_a_reg;
        end
        den_next = $unsigned(sq0_a_reg) + $unsigned(sq1_a_reg);
    end

    always_ff @(posedge aclk) begin
        if (en_b && v_a_reg) begin
            func_b_reg   <= func_a_reg;
            ab_b_reg     <= ab_a_reg;
            t_re_b_reg   <= t_re_next;
            t_im_b_reg   <= t_im_next;
            den_b_reg    <= den_next;
            add_re_b_reg <= add_re_a_reg;
            add_im_b_reg <= add_im_a_reg;
        end
    end

    // Stage C: rounding and saturation of the direct results, magnitudes of
    // the quotient numerators.
    logic signed [SF-1:0] tx_re, tx_im, ax_re, ax_im;
    logic [W:0]           e_re, e_im;
    cau_pkg::ctrl_t       ctrl_c_next;

    cau_pkg::ctrl_t       ctrl_c_reg;
    logic [4*W-1:0]       ab_c_reg;
    logic [DW-1:0]        mag_re_c_reg, mag_im_c_reg, den_c_reg;
    logic [W-1:0]         early_re_c_reg, early_im_c_reg;

    always_comb begin
        tx_re = t_re_b_reg;
        tx_im = t_im_b_reg;
        ax_re = add_re_b_reg;
        ax_im = add_im_b_reg;
        case (func_b_reg)
            cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
                e_re = sat_word(ax_re);
                e_im = sat_word(ax_im);
            end
            cau_pkg::FUNC_MUL: begin
                e_re = sat_word((tx_re + HALF) >>> F);
                e_im = sat_word((tx_im + HALF) >>> F);
            end
            default: begin
                e_re = '0;
                e_im = '0;
            end
        endcase
        ctrl_c_next.func   = func_b_reg;
        ctrl_c_next.dz     = (func_b_reg inside {cau_pkg::FUNC_DIV, cau_pkg::FUNC_QUOT,
                                                 cau_pkg::FUNC_REM}) && (den_b_reg == '0);
        ctrl_c_next.ovf    = e_re[W] | e_im[W];
        ctrl_c_next.neg_re = t_re_b_reg[DW];
        ctrl_c_next.neg_im = t_im_b_reg[DW];
        ctrl_c_next.big_re = 1'b0;
        ctrl_c_next.big_im = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en_c && v_b_reg) begin
            ctrl_c_reg     <= ctrl_c_next;
            ab_c_reg       <= ab_b_reg;
            mag_re_c_reg   <= t_re_b_reg[DW] ? DW'(-t_re_b_reg) : DW'(t_re_b_reg);
            mag_im_c_reg   <= t_im_b_reg[DW] ? DW'(-t_im_b_reg) : DW'(t_im_b_reg);
            den_c_reg      <= den_b_reg;
            early_re_c_reg <= e_re[W-1:0];
            early_im_c_reg <= e_im[W-1:0];
        end
    end

    // Stage D: dividend alignment and the quotient range check.
    logic [NM-1:0]  n_re, n_im;
    logic [HW-1:0]  hi_re, hi_im;
    logic           big_re, big_im;
    cau_pkg::ctrl_t ctrl_d_next;

    cau_pkg::ctrl_t ctrl_d_reg;
    logic [DW-1:0]  den_d_reg, r_re_d_reg, r_im_d_reg;
    logic [QB-1:0]  nlo_re_d_reg, nlo_im_d_reg;
    logic [6*W-1:0] side_d_reg;

    always_comb begin
        if (ctrl_c_reg.func == cau_pkg::FUNC_DIV) begin
            n_re = NM'(mag_re_c_reg) << F;
            n_im = NM'(mag_im_c_reg) << F;
        end else begin
            n_re = NM'(mag_re_c_reg);
            n_im = NM'(mag_im_c_reg);
        end
        hi_re  = n_re[NM-1:QB];
        hi_im  = n_im[NM-1:QB];
        big_re = CW'(hi_re) >= CW'(den_c_reg);
        big_im = CW'(hi_im) >= CW'(den_c_reg);
        ctrl_d_next        = ctrl_c_reg;
        ctrl_d_next.big_re = big_re;
        ctrl_d_next.big_im = big_im;
    end

    always_ff @(posedge aclk) begin
        if (en_d && v_c_reg) begin
            ctrl_d_reg   <= ctrl_d_next;
            den_d_reg    <= den_c_reg;
            r_re_d_reg   <= big_re ? '0 : DW'(hi_re);
            r_im_d_reg   <= big_im ? '0 : DW'(hi_im);
            nlo_re_d_reg <= n_re[QB-1:0];
            nlo_im_d_reg <= n_im[QB-1:0];
            side_d_reg   <= {ab_c_reg, early_re_c_reg, early_im_c_reg};
        end
    end

    assign out_valid  = v_d_reg;
    assign out_ctrl   = ctrl_d_reg;
    assign out_den    = den_d_reg;
    assign out_r_re   = r_re_d_reg;
    assign out_r_im   = r_im_d_reg;
    assign out_nlo_re = nlo_re_d_reg;
    assign out_nlo_im = nlo_im_d_reg;
    assign out_side   = side_d_reg;

endmodule

// ===== rtl/cau_iter.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// One registered step of the two restoring dividers and of the integer
// square root; the stage index selects the bit that it settles.
// ----------------------------------------------------------------------------
module cau_iter #(
    parameter int unsigned WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int unsigned IDX       = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cau_pkg::ctrl_t               in_ctrl,
    input  logic [2*WORD_BITS-1:0]       in_den,
    input  logic [2*WORD_BITS-1:0]       in_r_re,
    input  logic [2*WORD_BITS-1:0]       in_r_im,
    input  logic [WORD_BITS:0]           in_nlo_re,
    input  logic [WORD_BITS:0]           in_nlo_im,
    input  logic [WORD_BITS:0]           in_q_re,
    input  logic [WORD_BITS:0]           in_q_im,
    input  logic [WORD_BITS+1:0]         in_rem,
    input  logic [WORD_BITS-1:0]         in_root,
    input  logic [6*WORD_BITS-1:0]       in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cau_pkg::ctrl_t               out_ctrl,
    output logic [2*WORD_BITS-1:0]       out_den,
    output logic [2*WORD_BITS-1:0]       out_r_re,
    output logic [2*WORD_BITS-1:0]       out_r_im,
    output logic [WORD_BITS:0]           out_nlo_re,
    output logic [WORD_BITS:0]           out_nlo_im,
    output logic [WORD_BITS:0]           out_q_re,
    output logic [WORD_BITS:0]           out_q_im,
    output logic [WORD_BITS+1:0]         out_rem,
    output logic [WORD_BITS-1:0]         out_root,
    output logic [6*WORD_BITS-1:0]       out_side
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned QB = W + 1;
    localparam int unsigned DW = 2 * W;
    localparam int unsigned RW = W + 2;

    logic           v_reg;
    logic           en;
    logic [DW:0]    rs_re, rs_im;
    logic           ge_re, ge_im;
    logic [DW-1:0]  r_re_next, r_im_next;
    logic [QB-1:0]  q_re_next, q_im_next;
    logic [RW-1:0]  rem_next;
    logic [W-1:0]   root_next;

    cau_pkg::ctrl_t ctrl_reg;
    logic [DW-1:0]  den_reg, r_re_reg, r_im_reg;
    logic [QB-1:0]  nlo_re_reg, nlo_im_reg, q_re_reg, q_im_reg;
    logic [RW-1:0]  rem_reg;
    logic [W-1:0]   root_reg;
    logic [6*W-1:0] side_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        rs_re     = {in_r_re, in_nlo_re[QB-1-IDX]};
        rs_im     = {in_r_im, in_nlo_im[QB-1-IDX]};
        ge_re     = rs_re >= {1'b0, in_den};
        ge_im     = rs_im >= {1'b0, in_den};
        r_re_next = ge_re ? DW'(rs_re - {1'b0, in_den}) : rs_re[DW-1:0];
        r_im_next = ge_im ? DW'(rs_im - {1'b0, in_den}) : rs_im[DW-1:0];
        q_re_next = in_q_re;
        q_im_next = in_q_im;
        q_re_next[QB-1-IDX] = ge_re;
        q_im_next[QB-1-IDX] = ge_im;
    end

    generate
        if (IDX < W) begin : g_root
            logic [RW:0] remsh, trial;
            logic        sge;
            always_comb begin
                remsh     = {in_rem[W:0], in_den[DW-1-2*IDX -: 2]};
                trial     = ((RW+1)'(in_root >> (W - IDX)) << 2) | (RW+1)'(1);
                sge       = remsh >= trial;
                rem_next  = sge ? RW'(remsh - trial) : remsh[RW-1:0];
                root_next = in_root;
                root_next[W-1-IDX] = sge;
            end
        end else begin : g_hold
            always_comb begin
                rem_next  = in_rem;
                root_next = in_root;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            ctrl_reg   <= in_ctrl;
            den_reg    <= in_den;
            r_re_reg   <= r_re_next;
            r_im_reg   <= r_im_next;
            nlo_re_reg <= in_nlo_re;
            nlo_im_reg <= in_nlo_im;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = v_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_den    = den_reg;
    assign out_r_re   = r_re_reg;
    assign out_r_im   = r_im_reg;
    assign out_nlo_re = nlo_re_reg;
    assign out_nlo_im = nlo_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
    assign out_rem    = rem_reg;
    assign out_root   = root_reg;
    assign out_side   = side_reg;

endmodule

// ===== rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Four stages: signed quotient and final selection, remainder products,
// remainder sums, and the saturating output register.
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int unsigned WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int unsigned FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cau_pkg::ctrl_t               in_ctrl,
    input  logic [WORD_BITS:0]           in_q_re,
    input  logic [WORD_BITS:0]           in_q_im,
    input  logic [WORD_BITS-1:0]         in_root,
    input  logic [6*WORD_BITS-1:0]       in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [WORD_BITS-1:0]  out_res_re,
    output logic signed [WORD_BITS-1:0]  out_res_im,
    output logic                         out_div_zero,
    output logic                         out_overflow
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned QB = W + 1;
    localparam int unsigned PW = QB + 1 + W;
    localparam int unsigned SB = (2 * W + 4 > W + F + 3) ? 2 * W + 4 : W + F + 3;

    function automatic logic [W:0] sat_word(input logic signed [SB-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[SB-1:W-1];
        all_zeros = ~|v[SB-1:W-1];
        if (all_ones || all_zeros) begin
            sat_word = {1'b0, v[W-1:0]};
        end else begin
            sat_word = {1'b1, v[SB-1], {(W-1){~v[SB-1]}}};
        end
    endfunction

    logic v_e_reg, v_f_reg, v_g_reg, v_h_reg;
    logic en_e, en_f, en_g, en_h;

    assign en_h     = !v_h_reg || out_ready;
    assign en_g     = !v_g_reg || en_h;
    assign en_f     = !v_f_reg || en_g;
    assign en_e     = !v_e_reg || en_f;
    assign in_ready = en_e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_e_reg <= 1'b0;
            v_f_reg <= 1'b0;
            v_g_reg <= 1'b0;
            v_h_reg <= 1'b0;
        end else begin
            if (en_e) v_e_reg <= in_valid;
            if (en_f) v_f_reg <= v_e_reg;
            if (en_g) v_g_reg <= v_f_reg;
            if (en_h) v_h_reg <= v_g_reg;
        end
    end

    // Stage E: signed quotients and every result except the remainder.
    logic signed [QB:0]   qs_re, qs_im;
    logic signed [SB-1:0] qx_re, qx_im, rx;
    logic [W:0]           sr, si;

    logic                 rem_e_reg, dz_e_reg, ovf_e_reg;
    logic [W-1:0]         res_re_e_reg, res_im_e_reg;
    logic signed [QB:0]   qs_re_e_reg, qs_im_e_reg;
    logic [4*W-1:0]       ab_e_reg;

    always_comb begin
        qs_re = in_ctrl.neg_re ? -$signed({1'b0, in_q_re}) : $signed({1'b0, in_q_re});
        qs_im = in_ctrl.neg_im ? -$signed({1'b0, in_q_im}) : $signed({1'b0, in_q_im});
        qx_re = qs_re;
        qx_im = qs_im;
        rx    = $signed(SB'(in_root));
        case (in_ctrl.func)
            cau_pkg::FUNC_DIV: begin
                sr = in_ctrl.big_re ? {1'b1, in_ctrl.neg_re, {(W-1){~in_ctrl.neg_re}}}
                                    : sat_word(qx_re);
                si = in_ctrl.big_im ? {1'b1, in_ctrl.neg_im, {(W-1){~in_ctrl.neg_im}}}
                                    : sat_word(qx_im);
            end
            cau_pkg::FUNC_QUOT: begin
                sr = sat_word(qx_re <<< F);
                si = sat_word(qx_im <<< F);
            end
            cau_pkg::FUNC_MAG: begin
                sr = sat_word(rx);
                si = '0;
            end
            default: begin
                sr = {in_ctrl.ovf, in_side[2*W-1:W]};
                si = {1'b0, in_side[W-1:0]};
            end
        endcase
        if (in_ctrl.dz) begin
            sr = '0;
            si = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_e && in_valid) begin
            rem_e_reg    <= (in_ctrl.func == cau_pkg::FUNC_REM) && !in_ctrl.dz;
            dz_e_reg     <= in_ctrl.dz;
            ovf_e_reg    <= sr[W] | si[W];
            res_re_e_reg <= sr[W-1:0];
            res_im_e_reg <= si[W-1:0];
            qs_re_e_reg  <= qs_re;
            qs_im_e_reg  <= qs_im;
            ab_e_reg     <= in_side[6*W-1:2*W];
        end
    end

    // Stage F: products of the integer quotient with the divisor.
    logic                 rem_f_reg, dz_f_reg, ovf_f_reg;
    logic [W-1:0]         res_re_f_reg, res_im_f_reg;
    logic [2*W-1:0]       a_f_reg;
    logic signed [PW-1:0] pr1_f_reg, pr2_f_reg, pr3_f_reg, pr4_f_reg;

    always_ff @(posedge aclk) begin
        if (en_f && v_e_reg) begin
            rem_f_reg    <= rem_e_reg;
            dz_f_reg     <= dz_e_reg;
            ovf_f_reg    <= ovf_e_reg;
            res_re_f_reg <= res_re_e_reg;
            res_im_f_reg <= res_im_e_reg;
            a_f_reg      <= ab_e_reg[4*W-1:2*W];
            pr1_f_reg    <= qs_re_e_reg * $signed(ab_e_reg[2*W-1:W]);
            pr2_f_reg    <= qs_im_e_reg * $signed(ab_e_reg[W-1:0]);
            pr3_f_reg    <= qs_re_e_reg * $signed(ab_e_reg[W-1:0]);
            pr4_f_reg    <= qs_im_e_reg * $signed(ab_e_reg[2*W-1:W]);
        end
    end

    // Stage G: the quotient times the divisor.
    logic                 rem_g_reg, dz_g_reg, ovf_g_reg;
    logic [W-1:0]         res_re_g_reg, res_im_g_reg;
    logic [2*W-1:0]       a_g_reg;
    logic signed [PW:0]   x_re_g_reg, x_im_g_reg;

    always_ff @(posedge aclk) begin
        if (en_g && v_f_reg) begin
            rem_g_reg    <= rem_f_reg;
            dz_g_reg     <= dz_f_reg;
            ovf_g_reg    <= ovf_f_reg;
            res_re_g_reg <= res_re_f_reg;
            res_im_g_reg <= res_im_f_reg;
            a_g_reg      <= a_f_reg;
            x_re_g_reg   <= pr1_f_reg - pr2_f_reg;
            x_im_g_reg   <= pr3_f_reg + pr4_f_reg;
        end
    end

    // Stage H: remainder, saturation and the output register.
    logic signed [SB-1:0] ar_x, ai_x, xr_x, xi_x;
    logic [W:0]           yr, yi;

    logic                 dz_h_reg, ovf_h_reg;
    logic [W-1:0]         res_re_h_reg, res_im_h_reg;

    always_comb begin
        ar_x = $signed(a_g_reg[2*W-1:W]);
        ai_x = $signed(a_g_reg[W-1:0]);
        xr_x = x_re_g_reg;
        xi_x = x_im_g_reg;
        yr   = sat_word(ar_x - xr_x);
        yi   = sat_word(ai_x - xi_x);
    end

    always_ff @(posedge aclk) begin
        if (en_h && v_g_reg) begin
            dz_h_reg <= dz_g_reg;
            if (rem_g_reg) begin
                res_re_h_reg <= yr[W-1:0];
                res_im_h_reg <= yi[W-1:0];
                ovf_h_reg    <= yr[W] | yi[W];
            end else begin
                res_re_h_reg <= res_re_g_reg;
                res_im_h_reg <= res_im_g_reg;
                ovf_h_reg    <= ovf_g_reg;
            end
        end
    end

    assign out_valid    = v_h_reg;
    assign out_res_re   = res_re_h_reg;
    assign out_res_im   = res_im_h_reg;
    assign out_div_zero = dz_h_reg;
    assign out_overflow = ovf_h_reg;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Throughput: one transfer per cycle unless m_ready stalls the output; the quotient
// pipeline settles one quotient bit per stage, and a root bit in all but the last,
// over WORD_BITS + 1 stages, between four front and four back stages. Each stage
// holds its item only while the next one is full.
// Reset is synchronous and active low; it empties the pipeline.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Fixed-point complex add, subtract, multiply, divide, magnitude, truncated
// quotient and remainder, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int unsigned WORD_BITS = cau_pkg::CAU_WORD_BITS,
    parameter int unsigned FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_func,
    input  logic signed [WORD_BITS-1:0]  s_a_re,
    input  logic signed [WORD_BITS-1:0]  s_a_im,
    input  logic signed [WORD_BITS-1:0]  s_b_re,
    input  logic signed [WORD_BITS-1:0]  s_b_im,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [WORD_BITS-1:0]  m_res_re,
    output logic signed [WORD_BITS-1:0]  m_res_im,
    output logic                         m_div_zero,
    output logic                         m_overflow
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned QB = W + 1;
    localparam logic signed [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};

    logic               valid_w [0:QB];
    logic               ready_w [0:QB];
    cau_pkg::ctrl_t     ctrl_w  [0:QB];
    logic [2*W-1:0]     den_w   [0:QB];
    logic [2*W-1:0]     r_re_w  [0:QB];
    logic [2*W-1:0]     r_im_w  [0:QB];
    logic [QB-1:0]      nlo_re_w[0:QB];
    logic [QB-1:0]      nlo_im_w[0:QB];
    logic [QB-1:0]      q_re_w  [0:QB];
    logic [QB-1:0]      q_im_w  [0:QB];
    logic [W+1:0]       rem_w   [0:QB];
    logic [W-1:0]       root_w  [0:QB];
    logic [6*W-1:0]     side_w  [0:QB];

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_func    (s_func),
        .in_a_re    (s_a_re),
        .in_a_im    (s_a_im),
        .in_b_re    (s_b_re),
        .in_b_im    (s_b_im),
        .out_valid  (valid_w[0]),
        .out_ready  (ready_w[0]),
        .out_ctrl   (ctrl_w[0]),
        .out_den    (den_w[0]),
        .out_r_re   (r_re_w[0]),
        .out_r_im   (r_im_w[0]),
        .out_nlo_re (nlo_re_w[0]),
        .out_nlo_im (nlo_im_w[0]),
        .out_side   (side_w[0])
    );

    assign q_re_w[0] = '0;
    assign q_im_w[0] = '0;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;

    for (genvar i = 0; i < QB; i++) begin : g_iter
        cau_iter #(
            .WORD_BITS (WORD_BITS),
            .IDX       (i)
        ) u_iter (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (valid_w[i]),
            .in_ready   (ready_w[i]),
            .in_ctrl    (ctrl_w[i]),
            .in_den     (den_w[i]),
            .in_r_re    (r_re_w[i]),
            .in_r_im    (r_im_w[i]),
            .in_nlo_re  (nlo_re_w[i]),
            .in_nlo_im  (nlo_im_w[i]),
            .in_q_re    (q_re_w[i]),
            .in_q_im    (q_im_w[i]),
            .in_rem     (rem_w[i]),
            .in_root    (root_w[i]),
            .in_side    (side_w[i]),
            .out_valid  (valid_w[i+1]),
            .out_ready  (ready_w[i+1]),
            .out_ctrl   (ctrl_w[i+1]),
            .out_den    (den_w[i+1]),
            .out_r_re   (r_re_w[i+1]),
            .out_r_im   (r_im_w[i+1]),
            .out_nlo_re (nlo_re_w[i+1]),
            .out_nlo_im (nlo_im_w[i+1]),
            .out_q_re   (q_re_w[i+1]),
            .out_q_im   (q_im_w[i+1]),
            .out_rem    (rem_w[i+1]),
            .out_root   (root_w[i+1]),
            .out_side   (side_w[i+1])
        );
    end

    cau_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (valid_w[QB]),
        .in_ready     (ready_w[QB]),
        .in_ctrl      (ctrl_w[QB]),
        .in_q_re      (q_re_w[QB]),
        .in_q_im      (q_im_w[QB]),
        .in_root      (root_w[QB]),
        .in_side      (side_w[QB]),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_res_re   (m_res_re),
        .out_res_im   (m_res_im),
        .out_div_zero (m_div_zero),
        .out_overflow (m_overflow)
    );

    // The pipeline refuses input only when every stage, the output included, is full.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while the output register is empty");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented right after reset");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero |-> m_res_re == '0 && m_res_im == '0 && !m_overflow)
        else $error("zero divisor result is not zero");

    a_ovf_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_res_re == MAX_WORD || m_res_re == MIN_WORD ||
                                  m_res_im == MAX_WORD || m_res_im == MIN_WORD)
        else $error("overflow flagged without a saturated part");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives function codes and complex Q16.16 operands through the valid/ready
// input channel, predicts each result with exact wide arithmetic, and checks
// every result transfer field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int W = 160;
    localparam int FRAC = cau_pkg::CAU_FRAC_BITS;
    localparam logic [2:0] FUNC_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               dz;
        logic               ovf;
    } cau_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_func;
    logic signed [31:0] s_a_re;
    logic signed [31:0] s_a_im;
    logic signed [31:0] s_b_re;
    logic signed [31:0] s_b_im;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_res_re;
    logic signed [31:0] m_res_im;
    logic               m_div_zero;
    logic               m_overflow;

    cau_result_t pending_results[$];
    int          n_sent;
    int          n_checked;
    int          n_errors;
    int          n_div_zero;
    int          n_saturated;
    int          cycle_count;
    int          burst_left;

    complex_arithmetic_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_a_re     (s_a_re),
        .s_a_im     (s_a_im),
        .s_b_re     (s_b_re),
        .s_b_im     (s_b_im),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_re   (m_res_re),
        .m_res_im   (m_res_im),
        .m_div_zero (m_div_zero),
        .m_overflow (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [32:0] saturate(input logic signed [W-1:0] x);
        if (x > 160'sh7fffffff) begin
            return {1'b1, 32'h7fffffff};
        end else if (x < -160'sh80000000) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, x[31:0]};
    endfunction

    function automatic cau_result_t compute_complex(input logic [2:0] f,
            input logic signed [31:0] a_re, input logic signed [31:0] a_im,
            input logic signed [31:0] b_re, input logic signed [31:0] b_im);
        logic signed [W-1:0] ar, ai, br, bi, rr, ri, den, nr, ni, qr, qi, half;
        logic [W-1:0] mag_sq, root, bitv;
        logic [32:0] sat_re, sat_im;
        cau_result_t r;
        ar = a_re;
        ai = a_im;
        br = b_re;
        bi = b_im;
        rr = 0;
        ri = 0;
        r.dz = 1'b0;
        half = 1;
        half = half <<< (FRAC - 1);
        case (f)
            cau_pkg::FUNC_ADD: begin
                rr = ar + br;
                ri = ai + bi;
            end
            cau_pkg::FUNC_SUB: begin
                rr = ar - br;
                ri = ai - bi;
            end
            cau_pkg::FUNC_MUL: begin
                rr = (ar * br - ai * bi + half) >>> FRAC;
                ri = (ar * bi + ai * br + half) >>> FRAC;
            end
            cau_pkg::FUNC_MAG: begin
                mag_sq = ar * ar + ai * ai;
                root = 0;
                bitv = 1;
                bitv = bitv << (W - 2);
                while (bitv > mag_sq) bitv = bitv >> 2;
                while (bitv != 0) begin
                    if (mag_sq >= root + bitv) begin
                        mag_sq = mag_sq - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                rr = root;
            end
            cau_pkg::FUNC_DIV, cau_pkg::FUNC_QUOT, cau_pkg::FUNC_REM: begin
                den = br * br + bi * bi;
                nr = ar * br + ai * bi;
                ni = ai * br - ar * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else if (f == cau_pkg::FUNC_DIV) begin
                    rr = (nr <<< FRAC) / den;
                    ri = (ni <<< FRAC) / den;
                end else begin
                    qr = nr / den;
                    qi = ni / den;
                    if (f == cau_pkg::FUNC_QUOT) begin
                        rr = qr <<< FRAC;
                        ri = qi <<< FRAC;
                    end else begin
                        rr = ar - (qr * br - qi * bi);
                        ri = ai - (qr * bi + qi * br);
                    end
                end
            end
            default: begin
            end
        endcase
        sat_re = saturate(rr);
        sat_im = saturate(ri);
        r.re = sat_re[31:0];
        r.im = sat_im[31:0];
        r.ovf = sat_re[32] | sat_im[32];
        return r;
    endfunction

    // The sender idles only between bursts, so valid is never dropped mid-burst.
    task automatic transfer_item(input logic [2:0] f,
            input logic signed [31:0] a_re, input logic signed [31:0] a_im,
            input logic signed [31:0] b_re, input logic signed [31:0] b_im);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_func <= f;
        s_a_re <= a_re;
        s_a_im <= a_im;
        s_b_re <= b_re;
        s_b_im <= b_im;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(compute_complex(f, a_re, a_im, b_re, b_im));
        n_sent++;
    endtask

    function automatic logic signed [31:0] pick_word();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $signed($urandom_range(0, 8)) - 4 <<< 16;
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 0;
                    3: v = -1;
                    default: v = 32'sh00010000;
                endcase
            end
            2: v = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            3: v = $signed($urandom) >>> $urandom_range(0, 20);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [2:0] f;
        for (int i = 0; i < 8; i++) begin
            f = i[2:0];
            transfer_item(f, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
            if (f == cau_pkg::FUNC_DIV || f == cau_pkg::FUNC_QUOT ||
                f == cau_pkg::FUNC_REM) begin
                transfer_item(f, 32'sh00030000, -32'sh00050000, 0, 0);
            end
        end
        transfer_item(cau_pkg::FUNC_MUL, 32'sh00008000, 0, 1, 0);
        transfer_item(cau_pkg::FUNC_MUL, -32'sh00008000, 0, 1, 0);
        transfer_item(cau_pkg::FUNC_ADD, 32'sh7fffffff, 32'sh80000000, 1, -1);
        transfer_item(cau_pkg::FUNC_SUB, 32'sh80000000, 32'sh7fffffff, 1, -1);
        transfer_item(cau_pkg::FUNC_MAG, 32'sh80000000, 32'sh80000000, 0, 0);
        transfer_item(cau_pkg::FUNC_DIV, 32'sh7fffffff, 0, 1, 0);
        transfer_item(cau_pkg::FUNC_QUOT, 32'sh00070000, -32'sh00070000, 32'sh00020000, 0);
        transfer_item(cau_pkg::FUNC_REM, 32'sh00070000, -32'sh00070000, 32'sh00020000,
                      32'sh00010000);
        transfer_item(FUNC_NONE, -1, -1, -1, -1);
    endtask

    task automatic test_random_ops(input int count, input bit division_heavy);
        logic [2:0] f;
        logic signed [31:0] b_re, b_im;
        for (int i = 0; i < count; i++) begin
            if (division_heavy) begin
                f = ($urandom_range(0, 2) == 0) ? cau_pkg::FUNC_DIV
                  : ($urandom_range(0, 1) == 0) ? cau_pkg::FUNC_QUOT : cau_pkg::FUNC_REM;
            end else begin
                f = 3'($urandom_range(0, 7));
            end
            b_re = pick_word();
            b_im = pick_word();
            if ($urandom_range(0, 19) == 0) begin
                b_re = 0;
                b_im = 0;
            end
            transfer_item(f, pick_word(), pick_word(), b_re, b_im);
        end
    endtask

    // The receiver switches between always ready, light and heavy stalling.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 300) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cau_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with none expected: re=%h im=%h",
                         $time, m_res_re, m_res_im);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (m_res_re !== exp_res.re) begin
                    $display("%0t: res_re expected %h actual %h", $time, exp_res.re, m_res_re);
                    n_errors++;
                end
                if (m_res_im !== exp_res.im) begin
                    $display("%0t: res_im expected %h actual %h", $time, exp_res.im, m_res_im);
                    n_errors++;
                end
                if (m_div_zero !== exp_res.dz) begin
                    $display("%0t: div_zero expected %b actual %b", $time, exp_res.dz,
                             m_div_zero);
                    n_errors++;
                end
                if (m_overflow !== exp_res.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time, exp_res.ovf,
                             m_overflow);
                    n_errors++;
                end
                n_div_zero += exp_res.dz;
                n_saturated += exp_res.ovf;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = '0;
        s_a_re = '0;
        s_a_im = '0;
        s_b_re = '0;
        s_b_im = '0;
        m_ready = 1'b0;
        cycle_count = 0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        n_div_zero = 0;
        n_saturated = 0;
        burst_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_ops(700, 1'b0);
        test_random_ops(330, 1'b1);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d items, checked %0d results (%0d divide-by-zero, %0d saturated).",
                 n_sent, n_checked, n_div_zero, n_saturated);
        $display("Mismatches found: %0d.", n_errors);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
